// ----- src/fac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fac_pkg;

    localparam logic [30:0] ONE_MAG = 31'h3F80_0000;
    localparam logic [7:0]  EXP_MAX = 8'hFF;

    // operands for the single-precision subtractor plus early decision
    typedef struct packed {
        logic        decided;
        logic        result;
        logic        sa;
        logic [7:0]  ea;
        logic [22:0] fa;
        logic        sb;
        logic [7:0]  eb;
        logic [22:0] fb;
    } fac_op_t;

    // raw difference before normalization
    typedef struct packed {
        logic        decided;
        logic        result;
        logic [27:0] diff;
        logic [7:0]  exp;
    } fac_raw_t;

    // rounded magnitude of the difference
    typedef struct packed {
        logic        decided;
        logic        result;
        logic [30:0] mag;
    } fac_mag_t;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] cnt;
        cnt = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (v[i])
                cnt = 5'(26 - i);
        end
        return cnt;
    endfunction

endpackage
`default_nettype wire

// ----- src/fac_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fac_classify
    import fac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] x,
    input  wire logic [31:0] y,
    output fac_op_t          op_reg
);

    fac_op_t     op_next;
    logic        nan_x, nan_y, inf_x, inf_y, small_xy;
    logic        zero_x, zero_y, den_x, den_y;
    logic [8:0]  bx, by;

    always_comb
    begin
        nan_x    = (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
        nan_y    = (y[30:23] == EXP_MAX) && (y[22:0] != 23'd0);
        inf_x    = (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
        inf_y    = (y[30:23] == EXP_MAX) && (y[22:0] == 23'd0);
        small_xy = (x[30:0] <= ONE_MAG) && (y[30:0] <= ONE_MAG);
        zero_x   = (x[30:0] == 31'd0);
        zero_y   = (y[30:0] == 31'd0);
        den_x    = (x[30:23] == 8'd0) && !zero_x;
        den_y    = (y[30:23] == 8'd0) && !zero_y;
        // zero counts as exponent -1, the same as a biased field of 126
        bx = zero_x ? 9'd126 : {1'b0, x[30:23]};
        by = zero_y ? 9'd126 : {1'b0, y[30:23]};

        op_next = '0;
        op_next.sa = x[31];
        op_next.ea = x[30:23];
        op_next.fa = x[22:0];
        op_next.sb = y[31];
        op_next.eb = y[30:23];
        op_next.fb = y[22:0];

        if (nan_x || nan_y)
        begin
            op_next.decided = 1'b1;
            op_next.result  = nan_x && nan_y;
        end
        else if (inf_x || inf_y)
        begin
            op_next.decided = 1'b1;
            op_next.result  = inf_x && inf_y && (x[31] == y[31]);
        end
        else if (!small_xy)
        begin
            if ((x[31] != y[31]) || den_x || den_y || (bx > by + 9'd1) || (by > bx + 9'd1))
            begin
                op_next.decided = 1'b1;
                op_next.result  = 1'b0;
            end
            // mantissa compare: larger exponent gets 2^0, else 2^-1
            op_next.sa = 1'b0;
            op_next.sb = 1'b0;
            op_next.ea = zero_x ? 8'd0 : ((bx > by) ? 8'd127 : 8'd126);
            op_next.eb = zero_y ? 8'd0 : ((by > bx) ? 8'd127 : 8'd126);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            op_reg <= op_next;
    end

endmodule
`default_nettype wire

// ----- src/fac_fsub.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fac_fsub
    import fac_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire fac_op_t op,
    output fac_mag_t     mag_reg
);

    fac_raw_t    raw_reg, raw_next;
    fac_mag_t    mag_next;

    logic        swap, do_sub;
    logic [7:0]  ea_eff, eb_eff, el, es, d;
    logic [23:0] sig_a, sig_b, sig_l, sig_s;
    logic [26:0] ext_l, ext_s, shifted, lost_mask;
    logic        sticky;

    // align, then add or subtract
    always_comb
    begin
        ea_eff = (op.ea == 8'd0) ? 8'd1 : op.ea;
        eb_eff = (op.eb == 8'd0) ? 8'd1 : op.eb;
        sig_a  = {op.ea != 8'd0, op.fa};
        sig_b  = {op.eb != 8'd0, op.fb};
        swap   = {op.eb, op.fb} > {op.ea, op.fa};
        el     = swap ? eb_eff : ea_eff;
        es     = swap ? ea_eff : eb_eff;
        sig_l  = swap ? sig_b : sig_a;
        sig_s  = swap ? sig_a : sig_b;
        d      = el - es;
        ext_l  = {sig_l, 3'b000};
        ext_s  = {sig_s, 3'b000};
        if (d >= 8'd27)
        begin
            shifted   = '0;
            lost_mask = '1;
        end
        else
        begin
            shifted   = ext_s >> d;
            lost_mask = ~(27'h7FF_FFFF << d);
        end
        sticky = |(ext_s & lost_mask);
        do_sub = (op.sa == op.sb);

        raw_next.decided = op.decided;
        raw_next.result  = op.result;
        raw_next.exp     = el;
        raw_next.diff    = do_sub ? ({1'b0, ext_l} - {1'b0, shifted | {26'd0, sticky}})
                                  : ({1'b0, ext_l} + {1'b0, shifted | {26'd0, sticky}});
    end

    logic [4:0]  lz;
    logic [7:0]  lim, sh;
    logic [8:0]  e9;
    logic [26:0] n;
    logic [7:0]  field;
    logic        up;

    // normalize and round to nearest even
    always_comb
    begin
        lz  = lzc27(raw_reg.diff[26:0]);
        lim = raw_reg.exp - 8'd1;
        sh  = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
        if (raw_reg.diff[27])
        begin
            n  = {raw_reg.diff[27:2], raw_reg.diff[1] | raw_reg.diff[0]};
            e9 = {1'b0, raw_reg.exp} + 9'd1;
        end
        else
        begin
            n  = raw_reg.diff[26:0] << sh;
            e9 = {1'b0, raw_reg.exp - sh};
        end
        field = n[26] ? e9[7:0] : 8'd0;
        up    = n[2] && (n[1] || n[0] || n[3]);

        mag_next.decided = raw_reg.decided;
        mag_next.result  = raw_reg.result;
        mag_next.mag     = {field, n[25:3]} + {30'd0, up};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg <= raw_next;
            mag_reg <= mag_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/float_approx_equal_compare.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Approximate equality of two single-precision values. Each input word carries
// first_value in tdata[31:0] and second_value in tdata[63:32]; each output word
// carries approx_equal in tdata[0]. The block is a four-stage pipeline
// (classify, align and subtract, normalize and round, threshold compare) and
// takes one word per clock unless held; a result passes through op_reg,
// raw_reg, mag_reg and out_reg. The whole pipeline holds while the output
// word waits. The APB port writes the tolerance register at address 0.
module float_approx_equal_compare
    import fac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // first_value, second_value
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // approx_equal, zero fill
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic [31:0] tol_reg;
    logic [2:0]  vld_reg;
    logic        out_vld_reg, out_reg, out_next;
    logic        adv;
    fac_op_t     op;
    fac_mag_t    mag;

    logic        thr_nan;
    logic [30:0] thr_mag;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_reg};
    assign prdata        = tol_reg;
    assign pready        = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (psel && penable && pwrite && (paddr == 1'b0))
            tol_reg <= pwdata;
    end

    fac_classify u_classify (
        .clk    (clk),
        .en     (adv),
        .x      (s_axis_tdata[31:0]),
        .y      (s_axis_tdata[63:32]),
        .op_reg (op)
    );

    fac_fsub u_fsub (
        .clk     (clk),
        .en      (adv),
        .op      (op),
        .mag_reg (mag)
    );

    // threshold is tolerance doubled in single precision
    always_comb
    begin
        thr_nan = (tol_reg[30:23] == EXP_MAX) && (tol_reg[22:0] != 23'd0);
        if (tol_reg[30:23] == 8'd0)
            thr_mag = {tol_reg[29:0], 1'b0};
        else if (tol_reg[30:23] == EXP_MAX)
            thr_mag = tol_reg[30:0];
        else if (tol_reg[30:23] == 8'd254)
            thr_mag = {EXP_MAX, 23'd0};
        else
            thr_mag = {tol_reg[30:23] + 8'd1, tol_reg[22:0]};

        if (mag.decided)
            out_next = mag.result;
        else if (thr_nan)
            out_next = 1'b0;
        else if (tol_reg[31])
            out_next = (mag.mag == 31'd0) && (thr_mag == 31'd0);
        else
            out_next = (mag.mag <= thr_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[1:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

endmodule
`default_nettype wire
